// ===== rtl/rtph_pkg.sv =====
// Shared types, constants and the hdr_byte helper function of the RTP H.264 packetizer.
// Used by rtph_ctrl, rtph_serializer and the top level; it depends on nothing else.
`default_nettype none

package rtph_pkg;

   localparam int MAX_PACKET_BYTES = 1500;
   localparam int RTP_HDR_BYTES    = 12;
   localparam int FU_HDR_BYTES     = 2;

   localparam logic [15:0] ROOM_SINGLE   = 16'(MAX_PACKET_BYTES - RTP_HDR_BYTES);
   localparam logic [15:0] ROOM_FRAGMENT =
      16'(MAX_PACKET_BYTES - RTP_HDR_BYTES - FU_HDR_BYTES);

   localparam logic [3:0] LAST_INDEX_PAYLOAD  = 4'd0;
   localparam logic [3:0] LAST_INDEX_SINGLE   = 4'(RTP_HDR_BYTES);
   localparam logic [3:0] LAST_INDEX_FRAGMENT = 4'(RTP_HDR_BYTES + FU_HDR_BYTES);

   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [7:0] NRI_MASK         = 8'he0;
   localparam logic [7:0] NAL_TYPE_MASK    = 8'h1f;
   localparam logic [7:0] FU_A_TYPE        = 8'd28;
   localparam logic [7:0] FU_START_BIT     = 8'h80;
   localparam logic [7:0] FU_END_BIT       = 8'h40;

   localparam logic       CSR_PAYLOAD_TYPE = 1'b0;
   localparam logic       CSR_SSRC         = 1'b1;
   localparam logic [6:0] PAYLOAD_TYPE_RESET = 7'd96;

   typedef enum logic [1:0] {
      ACT_START    = 2'd0,
      ACT_SINGLE   = 2'd1,
      ACT_FRAGMENT = 2'd2,
      ACT_UNUSED   = 2'd3
   } rtph_action_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  data_byte;
      logic        first_of_packet;
      logic        last_of_packet_in;
      logic [15:0] payload_length;
      logic        marker;
      logic        end_fragment;
      logic [15:0] sequence_number;
      logic [31:0] timestamp;
   } rtph_req_type;

   typedef struct packed {
      logic [3:0]  last_index;
      logic [7:0]  mark_pt;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] ssrc;
      logic [7:0]  fu_ind;
      logic [7:0]  fu_hdr;
      logic [7:0]  data;
      logic        last;
      logic        ovf;
   } rtph_desc_type;

   function automatic logic [7:0] hdr_byte(input rtph_desc_type desc, input logic [3:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (idx)
         4'd0:    b = RTP_VERSION_BYTE;
         4'd1:    b = desc.mark_pt;
         4'd2:    b = desc.seq[15:8];
         4'd3:    b = desc.seq[7:0];
         4'd4:    b = desc.ts[31:24];
         4'd5:    b = desc.ts[23:16];
         4'd6:    b = desc.ts[15:8];
         4'd7:    b = desc.ts[7:0];
         4'd8:    b = desc.ssrc[31:24];
         4'd9:    b = desc.ssrc[23:16];
         4'd10:   b = desc.ssrc[15:8];
         4'd11:   b = desc.ssrc[7:0];
         4'd12:   b = desc.fu_ind;
         4'd13:   b = desc.fu_hdr;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rtph_ctrl.sv =====
// Request decoder of the RTP H.264 packetizer: configuration registers, NAL
// state, overflow check and the result descriptor. Depends on rtph_pkg.
`default_nettype none

module rtph_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_write,
   input  wire                    csr_index,
   input  wire [31:0]             csr_wdata,
   input  wire                    take,
   input  rtph_pkg::rtph_req_type req,
   output logic                   load,
   output rtph_pkg::rtph_desc_type desc
);

   logic [6:0]  payload_type_ff, payload_type_in;
   logic [31:0] ssrc_ff, ssrc_in;
   logic [7:0]  nal_ff, nal_in;
   logic        pend_ff, pend_in;
   logic        drop_ff, drop_in;

   logic        is_payload;
   logic        is_frag;
   logic        too_long;
   logic        mark;
   logic [7:0]  fu_flags;

   always_ff @(posedge clock) begin
      if (reset) begin
         payload_type_ff <= rtph_pkg::PAYLOAD_TYPE_RESET;
         ssrc_ff         <= 32'h0;
         nal_ff          <= 8'h00;
         pend_ff         <= 1'b0;
         drop_ff         <= 1'b0;
      end else begin
         payload_type_ff <= payload_type_in;
         ssrc_ff         <= ssrc_in;
         nal_ff          <= nal_in;
         pend_ff         <= pend_in;
         drop_ff         <= drop_in;
      end
   end

   always_comb begin
      payload_type_in = payload_type_ff;
      ssrc_in         = ssrc_ff;
      if (csr_write) begin
         unique case (csr_index)
            rtph_pkg::CSR_PAYLOAD_TYPE: payload_type_in = csr_wdata[6:0];
            rtph_pkg::CSR_SSRC:         ssrc_in         = csr_wdata;
            default:                    ;
         endcase
      end
   end

   always_comb begin
      is_frag    = (req.action == rtph_pkg::ACT_FRAGMENT);
      is_payload = (req.action == rtph_pkg::ACT_SINGLE) || is_frag;
      too_long   = is_frag ? (req.payload_length > rtph_pkg::ROOM_FRAGMENT)
                           : (req.payload_length > rtph_pkg::ROOM_SINGLE);
      mark       = is_frag ? (req.marker && req.end_fragment) : req.marker;
      if (pend_ff) begin
         fu_flags = rtph_pkg::FU_START_BIT;
      end else if (req.end_fragment) begin
         fu_flags = rtph_pkg::FU_END_BIT;
      end else begin
         fu_flags = 8'h00;
      end

      nal_in  = nal_ff;
      pend_in = pend_ff;
      drop_in = drop_ff;
      load    = 1'b0;

      desc.mark_pt = {mark, payload_type_ff};
      desc.seq     = req.sequence_number;
      desc.ts      = req.timestamp;
      desc.ssrc    = ssrc_ff;
      desc.fu_ind  = (nal_ff & rtph_pkg::NRI_MASK) | rtph_pkg::FU_A_TYPE;
      desc.fu_hdr  = (nal_ff & rtph_pkg::NAL_TYPE_MASK) | fu_flags;
      desc.data    = req.data_byte;
      desc.last    = req.last_of_packet_in;
      desc.ovf     = 1'b0;
      desc.last_index = rtph_pkg::LAST_INDEX_PAYLOAD;

      if (take) begin
         if (req.action == rtph_pkg::ACT_START) begin
            nal_in  = req.data_byte;
            pend_in = 1'b1;
         end else if (is_payload) begin
            if (!req.first_of_packet) begin
               if (drop_ff) begin
                  if (req.last_of_packet_in) begin
                     drop_in = 1'b0;
                  end
               end else begin
                  load = 1'b1;
               end
            end else if (too_long) begin
               drop_in   = !req.last_of_packet_in;
               load      = 1'b1;
               desc.data = 8'h00;
               desc.last = 1'b1;
               desc.ovf  = 1'b1;
            end else begin
               drop_in = 1'b0;
               load    = 1'b1;
               if (is_frag) begin
                  desc.last_index = rtph_pkg::LAST_INDEX_FRAGMENT;
                  pend_in         = 1'b0;
               end else begin
                  desc.last_index = rtph_pkg::LAST_INDEX_SINGLE;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rtph_serializer.sv =====
// Result register and byte serializer of the RTP H.264 packetizer: walks one
// descriptor out as header bytes and the payload byte. Depends on rtph_pkg.
`default_nettype none

module rtph_serializer (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     load,
   input  rtph_pkg::rtph_desc_type desc,
   output logic                    free,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_packet_end,
   output logic                    rsp_overflow_error
);

   logic                    valid_ff, valid_in;
   logic [3:0]              idx_ff, idx_in;
   rtph_pkg::rtph_desc_type desc_ff;

   logic at_last;
   logic sent;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 4'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= desc;
      end
   end

   always_comb begin
      at_last  = (idx_ff == desc_ff.last_index);
      sent     = valid_ff && !rsp_stall;
      free     = !valid_ff || (sent && at_last);
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = 4'd0;
      end else if (sent) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end

      rsp_valid          = valid_ff;
      rsp_out_byte       = at_last ? desc_ff.data : rtph_pkg::hdr_byte(desc_ff, idx_ff);
      rsp_packet_end     = at_last && desc_ff.last;
      rsp_overflow_error = at_last && desc_ff.ovf;
   end

endmodule

`default_nettype wire

// ===== rtl/rtp_h264_packetizer.sv =====
// Top level of the RTP H.264 packetizer with FU-A fragmentation.
// Instantiates rtph_ctrl and rtph_serializer; depends on rtph_pkg.
//
//   Channel   Direction   Handshake              Contents
//   req_*     in          req_valid / req_stall  action, byte, packet marks, header fields
//   rsp_*     out         rsp_valid / rsp_stall  packet byte, packet end, overflow
//   csr_*     in          csr_write              register index and write data
//
// A first byte of a packet that fits yields 13 bytes in single mode and 15 in
// fragment mode; other payload requests yield one byte, start, unused or dropped none.
// The serializer holds one request's bytes; a new request enters in the cycle its
// last byte is taken. Synchronous active-high reset, no clearing pass.
// A stalled result also stalls the request side.
`default_nettype none

module rtp_h264_packetizer (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_write,
   input  wire         csr_index,
   input  wire  [31:0] csr_wdata,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_action,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_first_of_packet,
   input  wire         req_last_of_packet_in,
   input  wire  [15:0] req_payload_length,
   input  wire         req_marker,
   input  wire         req_end_fragment,
   input  wire  [15:0] req_sequence_number,
   input  wire  [31:0] req_timestamp,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_overflow_error
);

   rtph_pkg::rtph_req_type  req;
   rtph_pkg::rtph_desc_type desc;
   logic                    load;
   logic                    free;
   logic                    take;

   assign req.action            = req_action;
   assign req.data_byte         = req_data_byte;
   assign req.first_of_packet   = req_first_of_packet;
   assign req.last_of_packet_in = req_last_of_packet_in;
   assign req.payload_length    = req_payload_length;
   assign req.marker            = req_marker;
   assign req.end_fragment      = req_end_fragment;
   assign req.sequence_number   = req_sequence_number;
   assign req.timestamp         = req_timestamp;

   assign req_stall = !free;
   assign take      = req_valid && free;

   rtph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .take      (take),
      .req       (req),
      .load      (load),
      .desc      (desc)
   );

   rtph_serializer u_ser (
      .clock              (clock),
      .reset              (reset),
      .load               (load),
      .desc               (desc),
      .free               (free),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_packet_end     (rsp_packet_end),
      .rsp_overflow_error (rsp_overflow_error)
   );

endmodule

`default_nettype wire

// ===== rtl/rtph_checker.sv =====
// Port-level checks of the RTP H.264 packetizer, bound to its top level.
// Depends only on the ports of rtp_h264_packetizer.
`default_nettype none

module rtph_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [7:0]  rsp_out_byte,
   input wire        rsp_packet_end,
   input wire        rsp_overflow_error
);

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled while no result is pending");

   a_blocked_result_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while a result is held");

   a_overflow_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow_error |-> rsp_packet_end && rsp_out_byte == 8'h00)
      else $error("overflow result is not a zero packet end");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                 && $stable(rsp_packet_end))
      else $error("stalled result changed");

endmodule

bind rtp_h264_packetizer rtph_checker u_rtph_checker (.*);

`default_nettype wire

// ===== tb/tb_rtp_h264_packetizer.sv =====
// Self-checking testbench for the RTP H.264 packetizer with FU-A fragmentation.
// It drives a directed table and then random packet streams, and checks every byte.
// Depends on rtph_pkg and rtp_h264_packetizer.
`timescale 1ns / 1ps

module tb_rtp_h264_packetizer;

   localparam int PKT_LIMIT       = rtph_pkg::MAX_PACKET_BYTES;
   localparam int SINGLE_ROOM     = PKT_LIMIT - 12;
   localparam int FRAG_ROOM       = PKT_LIMIT - 14;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 40;
   localparam int NUM_ROWS        = 24;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       overflow_error;
   } pkt_byte_type;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_ONE
   } check_kind_type;

   typedef struct packed {
      rtph_pkg::rtph_req_type req;
      check_kind_type         kind;
      pkt_byte_type           want;
   } stim_row_type;

   localparam pkt_byte_type NO_BYTE  = '0;
   localparam pkt_byte_type OVF_BYTE = '{8'h00, 1'b1, 1'b1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_action = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_first_of_packet = 1'b0;
   logic        req_last_of_packet_in = 1'b0;
   logic [15:0] req_payload_length = '0;
   logic        req_marker = 1'b0;
   logic        req_end_fragment = 1'b0;
   logic [15:0] req_sequence_number = '0;
   logic [31:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_packet_end;
   logic        rsp_overflow_error;

   rtp_h264_packetizer u_top (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_data_byte         (req_data_byte),
      .req_first_of_packet   (req_first_of_packet),
      .req_last_of_packet_in (req_last_of_packet_in),
      .req_payload_length    (req_payload_length),
      .req_marker            (req_marker),
      .req_end_fragment      (req_end_fragment),
      .req_sequence_number   (req_sequence_number),
      .req_timestamp         (req_timestamp),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_packet_end        (rsp_packet_end),
      .rsp_overflow_error    (rsp_overflow_error)
   );

   always #5 clock = ~clock;

   pkt_byte_type expected_bytes[$];
   pkt_byte_type step_bytes[$];

   logic [6:0]  cur_payload_type;
   logic [31:0] cur_ssrc;
   logic [7:0]  nal_hdr;
   logic        start_bit_armed;
   logic        drop_active;

   bit quiet_phase = 1'b0;
   bit hold_off_request = 1'b0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int effective_items = 0;
   int bytes_checked = 0;
   int packets_seen = 0;
   int overflows_seen = 0;
   int hold_offs_done = 0;

   stim_row_type stim_rows [NUM_ROWS];

   function automatic void queue_byte(input logic [7:0] b, input logic e, input logic o);
      step_bytes.push_back('{b, e, o});
   endfunction

   task automatic predict_packet_bytes(input rtph_pkg::rtph_req_type r);
      logic [15:0] room;
      logic        frag;
      logic        mark;
      logic [7:0]  fu;
      frag = (r.action == rtph_pkg::ACT_FRAGMENT);
      if (r.action == rtph_pkg::ACT_START) begin
         nal_hdr = r.data_byte;
         start_bit_armed = 1'b1;
         return;
      end
      if (r.action == rtph_pkg::ACT_UNUSED) return;
      if (!r.first_of_packet) begin
         if (drop_active) begin
            if (r.last_of_packet_in) drop_active = 1'b0;
            return;
         end
         queue_byte(r.data_byte, r.last_of_packet_in, 1'b0);
         return;
      end
      room = frag ? 16'(FRAG_ROOM) : 16'(SINGLE_ROOM);
      if (r.payload_length > room) begin
         drop_active = !r.last_of_packet_in;
         queue_byte(8'h00, 1'b1, 1'b1);
         return;
      end
      drop_active = 1'b0;
      mark = r.marker && (!frag || r.end_fragment);
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte({mark, cur_payload_type}, 1'b0, 1'b0);
      queue_byte(r.sequence_number[15:8], 1'b0, 1'b0);
      queue_byte(r.sequence_number[7:0], 1'b0, 1'b0);
      queue_byte(r.timestamp[31:24], 1'b0, 1'b0);
      queue_byte(r.timestamp[23:16], 1'b0, 1'b0);
      queue_byte(r.timestamp[15:8], 1'b0, 1'b0);
      queue_byte(r.timestamp[7:0], 1'b0, 1'b0);
      queue_byte(cur_ssrc[31:24], 1'b0, 1'b0);
      queue_byte(cur_ssrc[23:16], 1'b0, 1'b0);
      queue_byte(cur_ssrc[15:8], 1'b0, 1'b0);
      queue_byte(cur_ssrc[7:0], 1'b0, 1'b0);
      if (frag) begin
         queue_byte({nal_hdr[7:5], 5'd0} + 8'd28, 1'b0, 1'b0);
         fu = {3'd0, nal_hdr[4:0]};
         if (start_bit_armed) begin
            start_bit_armed = 1'b0;
            fu = fu | 8'h80;
         end else if (r.end_fragment) begin
            fu = fu | 8'h40;
         end
         queue_byte(fu, 1'b0, 1'b0);
      end
      queue_byte(r.data_byte, r.last_of_packet_in, 1'b0);
   endtask

   function automatic int next_gap(input bit quiet);
      int pick;
      if (quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input rtph_pkg::rtph_req_type r, input check_kind_type kind,
                               input pkt_byte_type want);
      int gap;
      gap = next_gap(quiet_phase);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_action            = r.action;
      req_data_byte         = r.data_byte;
      req_first_of_packet   = r.first_of_packet;
      req_last_of_packet_in = r.last_of_packet_in;
      req_payload_length    = r.payload_length;
      req_marker            = r.marker;
      req_end_fragment      = r.end_fragment;
      req_sequence_number   = r.sequence_number;
      req_timestamp         = r.timestamp;
      req_valid             = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_bytes.delete();
      predict_packet_bytes(r);
      case (kind)
         CHK_MODEL: begin
            foreach (step_bytes[i]) expected_bytes.push_back(step_bytes[i]);
         end
         CHK_ONE: begin
            expected_bytes.push_back(want);
         end
         default: begin
         end
      endcase
      requests_sent++;
      if (step_bytes.size() != 0 || r.action == rtph_pkg::ACT_START) effective_items++;
   endtask

   function automatic rtph_pkg::rtph_req_type random_request();
      rtph_pkg::rtph_req_type r;
      r.action            = 2'($urandom_range(0, 3));
      r.data_byte         = 8'($urandom);
      r.first_of_packet   = 1'($urandom);
      r.last_of_packet_in = 1'($urandom);
      r.payload_length    = 16'($urandom);
      r.marker            = 1'($urandom);
      r.end_fragment      = 1'($urandom);
      r.sequence_number   = 16'($urandom);
      r.timestamp         = $urandom;
      return r;
   endfunction

   function automatic logic [15:0] pick_length(input int room);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 16'($urandom_range(1, 64));
      if (pick < 58) return 16'd0;
      if (pick < 68) return 16'(room);
      if (pick < 78) return 16'(room + 1);
      if (pick < 88) return 16'($urandom_range(room + 1, 65535));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_packet(input rtph_pkg::rtph_action_type act, input logic endf);
      rtph_pkg::rtph_req_type r;
      int          nbytes;
      logic [15:0] len;
      logic [15:0] seq;
      logic [31:0] ts;
      logic        mark;
      nbytes = $urandom_range(1, 5);
      len    = pick_length(act == rtph_pkg::ACT_FRAGMENT ? FRAG_ROOM : SINGLE_ROOM);
      seq    = 16'($urandom);
      ts     = $urandom;
      mark   = 1'($urandom);
      for (int i = 0; i < nbytes; i++) begin
         r = random_request();
         r.action            = act;
         r.first_of_packet   = (i == 0);
         r.last_of_packet_in = (i == nbytes - 1);
         if ($urandom_range(0, 19) == 0) r.last_of_packet_in = !r.last_of_packet_in;
         r.payload_length    = len;
         r.marker            = mark;
         r.end_fragment      = endf;
         r.sequence_number   = seq;
         r.timestamp         = ts;
         send_request(r, CHK_MODEL, NO_BYTE);
      end
   endtask

   task automatic run_random(input int target);
      int          stop_at;
      int          pick;
      int          npk;
      rtph_pkg::rtph_req_type r;
      stop_at = effective_items + target;
      while (effective_items < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            send_request(random_request(), CHK_MODEL, NO_BYTE);
         end else if (pick < 45) begin
            send_packet(rtph_pkg::ACT_SINGLE, 1'($urandom));
         end else begin
            r = random_request();
            r.action = rtph_pkg::ACT_START;
            send_request(r, CHK_MODEL, NO_BYTE);
            npk = $urandom_range(1, 3);
            for (int j = 0; j < npk; j++) begin
               send_packet(rtph_pkg::ACT_FRAGMENT,
                           (j == npk - 1) ^ ($urandom_range(0, 9) == 0));
            end
         end
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == rtph_pkg::CSR_PAYLOAD_TYPE) cur_payload_type = value[6:0];
      else cur_ssrc = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic report_mismatch(input pkt_byte_type want, input pkt_byte_type got,
                                  input bit orphan);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (orphan)
            $display("[%0t] unexpected result: byte %02h end %0b ovf %0b", $realtime,
                     got.out_byte, got.packet_end, got.overflow_error);
         else
            $display("[%0t] mismatch: expected byte %02h end %0b ovf %0b, got %02h %0b %0b",
                     $realtime, want.out_byte, want.packet_end, want.overflow_error,
                     got.out_byte, got.packet_end, got.overflow_error);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      pkt_byte_type got;
      pkt_byte_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_byte, rsp_packet_end, rsp_overflow_error};
         if (got.packet_end) packets_seen++;
         if (got.overflow_error) overflows_seen++;
         if (expected_bytes.size() == 0) begin
            report_mismatch(NO_BYTE, got, 1'b1);
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got !== want) report_mismatch(want, got, 1'b0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d bytes outstanding", cycle_count,
                  expected_bytes.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : rsp_side
      int stall_left;
      int held;
      stall_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall = 1'b1;
            held = 0;
            while (held < HOLD_OFF_CYCLES) begin
               @(negedge clock);
               held++;
            end
            hold_offs_done++;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else begin
            stall_left = next_gap(quiet_phase);
            rsp_stall = (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   initial begin : req_side
      stim_rows = '{
         '{'{rtph_pkg::ACT_UNUSED, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1,
             16'hFFFF, 32'hFFFF_FFFF}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'h00, 1'b1, 1'b1, 16'd1, 1'b1, 1'b0,
             16'hFFFF, 32'hFFFF_FFFF}, CHK_MODEL, NO_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'hFF, 1'b1, 1'b0, 16'd0, 1'b0, 1'b1,
             16'h0000, 32'h0000_0000}, CHK_MODEL, NO_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'hA5, 1'b0, 1'b0, 16'd7, 1'b1, 1'b0,
             16'h1234, 32'h0000_0000}, CHK_ONE, '{8'hA5, 1'b0, 1'b0}},
         '{'{rtph_pkg::ACT_SINGLE, 8'h5A, 1'b0, 1'b1, 16'd7, 1'b0, 1'b0,
             16'h1234, 32'h0000_0000}, CHK_ONE, '{8'h5A, 1'b1, 1'b0}},
         '{'{rtph_pkg::ACT_SINGLE, 8'h81, 1'b1, 1'b1, 16'd1488, 1'b1, 1'b1,
             16'h8001, 32'h8000_0001}, CHK_MODEL, NO_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'h42, 1'b1, 1'b0, 16'd1489, 1'b1, 1'b0,
             16'h0101, 32'h0101_0101}, CHK_ONE, OVF_BYTE},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h43, 1'b0, 1'b0, 16'd2, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_UNUSED, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'h44, 1'b0, 1'b1, 16'd2, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'h3C, 1'b0, 1'b1, 16'd2, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_ONE, '{8'h3C, 1'b1, 1'b0}},
         '{'{rtph_pkg::ACT_SINGLE, 8'h99, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1,
             16'hAAAA, 32'h5555_AAAA}, CHK_ONE, OVF_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'h11, 1'b0, 1'b0, 16'd3, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_ONE, '{8'h11, 1'b0, 1'b0}},
         '{'{rtph_pkg::ACT_START, 8'hFF, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h12, 1'b1, 1'b0, 16'd1486, 1'b1, 1'b0,
             16'h7FFF, 32'h7FFF_FFFF}, CHK_MODEL, NO_BYTE},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h13, 1'b0, 1'b1, 16'd5, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_ONE, '{8'h13, 1'b1, 1'b0}},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h14, 1'b1, 1'b1, 16'd10, 1'b1, 1'b0,
             16'h0102, 32'h0304_0506}, CHK_MODEL, NO_BYTE},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h15, 1'b1, 1'b1, 16'd3, 1'b1, 1'b1,
             16'h0103, 32'h0708_090A}, CHK_MODEL, NO_BYTE},
         '{'{rtph_pkg::ACT_START, 8'h65, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h16, 1'b1, 1'b0, 16'd1487, 1'b1, 1'b1,
             16'h0104, 32'h0B0C_0D0E}, CHK_ONE, OVF_BYTE},
         '{'{rtph_pkg::ACT_START, 8'h00, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h17, 1'b0, 1'b1, 16'd0, 1'b0, 1'b0,
             16'h0000, 32'h0000_0000}, CHK_NONE, NO_BYTE},
         '{'{rtph_pkg::ACT_FRAGMENT, 8'h18, 1'b1, 1'b1, 16'd1, 1'b0, 1'b1,
             16'h0105, 32'h0F10_1112}, CHK_MODEL, NO_BYTE},
         '{'{rtph_pkg::ACT_SINGLE, 8'h19, 1'b1, 1'b1, 16'd1, 1'b1, 1'b1,
             16'h0106, 32'h1314_1516}, CHK_MODEL, NO_BYTE}
      };

      cur_payload_type = 7'd96;
      cur_ssrc         = 32'd0;
      nal_hdr          = 8'd0;
      start_bit_armed  = 1'b0;
      drop_active      = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         send_request(stim_rows[i].req, stim_rows[i].kind, stim_rows[i].want);
      end
      wait_idle();

      write_register(rtph_pkg::CSR_PAYLOAD_TYPE, 32'hFFFF_FFFF);
      write_register(rtph_pkg::CSR_SSRC, 32'hFFFF_FFFF);
      quiet_phase = 1'b1;
      run_random(15);
      wait_idle();

      write_register(rtph_pkg::CSR_PAYLOAD_TYPE, 32'h0000_0000);
      write_register(rtph_pkg::CSR_SSRC, 32'h0000_0000);
      quiet_phase = 1'b0;
      hold_off_request = 1'b1;
      run_random(20);
      wait_idle();

      write_register(rtph_pkg::CSR_PAYLOAD_TYPE, $urandom);
      write_register(rtph_pkg::CSR_SSRC, $urandom);
      run_random(25);
      wait_idle();

      $display("Ran %0d requests (%0d with an effect) under four register settings.",
               requests_sent, effective_items);
      $display("Checked %0d bytes: %0d packet ends, %0d overflows, %0d long hold-offs.",
               bytes_checked, packets_seen, overflows_seen, hold_offs_done);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches in total", mismatch_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rtph_pkg.sv
rtl/rtph_ctrl.sv
rtl/rtph_serializer.sv
rtl/rtp_h264_packetizer.sv
rtl/rtph_checker.sv
tb/tb_rtp_h264_packetizer.sv
